@@ sv/spp_pkg.sv @@
`timescale 1ns / 1ps

package spp_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_PLAYER_X       = 3'd0,
        REG_PLAYER_Y       = 3'd1,
        REG_VIEW_DIR_X     = 3'd2,
        REG_VIEW_DIR_Y     = 3'd3,
        REG_CAMERA_PLANE_X = 3'd4,
        REG_CAMERA_PLANE_Y = 3'd5,
        REG_SCREEN_WIDTH   = 3'd6,
        REG_SCREEN_HEIGHT  = 3'd7
    } spp_reg_t;

    // Camera transform divider: |num| * 2^14 over |det|.
    localparam int CamNumW = 48;
    localparam int CamDenW = 33;
    localparam int CamQW   = 24;

    // Projection dividers: center and size over |depth|.
    localparam int CtrNumW  = 37;
    localparam int SizeNumW = 21;
    localparam int ProjDenW = 24;
    localparam int ProjQW   = 16;

    localparam int CamLat  = CamQW + 1;
    localparam int ProjLat = ProjQW + 1;

    typedef struct packed {
        logic neg_cam;
        logic neg_dep;
        logic det_zero;
    } spp_cam_side_t;

    typedef struct packed {
        logic signed [23:0] depth;
        logic               depth_zero;
        logic               prod_neg;
        logic               prod_zero;
    } spp_proj_side_t;

endpackage

@@ sv/spp_div.sv @@
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per pipeline stage.
// ovf flags a quotient that does not fit in QW bits.
module spp_div
    import spp_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 33,
    parameter int QW = 24
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          ovf
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic          v_reg   [QW+1];
    logic [W-1:0]  rem_reg [QW+1];
    logic [DW-1:0] d_reg   [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          ovf_reg [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= W'(num);
        d_reg[0]   <= den;
        q_reg[0]   <= '0;
        ovf_reg[0] <= W'(num) >= (W'(den) << QW);
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [W-1:0]  trial;
        logic          fits;
        logic [W-1:0]  rem_next;
        logic [QW-1:0] q_next;

        always_comb
        begin
            trial    = W'(d_reg[i]) << (QW - 1 - i);
            fits     = rem_reg[i] >= trial;
            rem_next = fits ? rem_reg[i] - trial : rem_reg[i];
            q_next   = q_reg[i];
            q_next[QW-1-i] = fits;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= rem_next;
            d_reg[i+1]   <= d_reg[i];
            q_reg[i+1]   <= q_next;
            ovf_reg[i+1] <= ovf_reg[i];
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = q_reg[QW];
    assign ovf       = ovf_reg[QW];

endmodule

@@ sv/sprite_screen_projection.sv @@
`timescale 1ns / 1ps
// The start transfer reaches the done strobe through the two chains of
// one-bit-per-stage dividers (25 stages, then 17 stages) plus 7 stages of math.
// Throughput: one sprite per cycle; busy is always low and results leave one per cycle.
// Reset clears all valid bits and loads the configuration registers with their defaults.
// The receiver cannot stall, so no result is ever held back.
module sprite_screen_projection
    import spp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        sprite_pos_x,
    input  logic [15:0]        sprite_pos_y,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] center_column,
    output logic signed [23:0] depth,
    output logic [15:0]        sprite_size,
    output logic signed [15:0] row_start,
    output logic signed [15:0] row_end,
    output logic signed [15:0] column_start,
    output logic signed [15:0] column_end,
    output logic               depth_zero
);

    logic [15:0]        player_x_reg, player_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [12:0]        width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg <= 16'd0;
            player_y_reg <= 16'd0;
            dir_x_reg    <= 16'sd16384;
            dir_y_reg    <= 16'sd0;
            plane_x_reg  <= 16'sd0;
            plane_y_reg  <= 16'sd10813;
            width_reg    <= 13'd640;
            height_reg   <= 13'd480;
        end
        else if (cfg_we)
        begin
            case (spp_reg_t'(cfg_index))
                REG_PLAYER_X:       player_x_reg <= cfg_data;
                REG_PLAYER_Y:       player_y_reg <= cfg_data;
                REG_VIEW_DIR_X:     dir_x_reg    <= cfg_data;
                REG_VIEW_DIR_Y:     dir_y_reg    <= cfg_data;
                REG_CAMERA_PLANE_X: plane_x_reg  <= cfg_data;
                REG_CAMERA_PLANE_Y: plane_y_reg  <= cfg_data;
                REG_SCREEN_WIDTH:   width_reg    <= cfg_data[12:0];
                REG_SCREEN_HEIGHT:  height_reg   <= cfg_data[12:0];
                default:            ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Valid bits of the math stages outside the dividers.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic cam_valid, proj_valid;

    // Both dividers of a pair run in lockstep; their valids match.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= cam_valid & dep_valid;
            v5_reg <= v4_reg;
            v6_reg <= proj_valid & size_valid;
            v7_reg <= v6_reg;
        end
    end

    // Stage 1: offset from the player.
    logic signed [16:0] sx_reg, sy_reg;

    always_ff @(posedge clk)
    begin
        sx_reg <= $signed({1'b0, sprite_pos_x}) - $signed({1'b0, player_x_reg});
        sy_reg <= $signed({1'b0, sprite_pos_y}) - $signed({1'b0, player_y_reg});
    end

    // Stage 2: products.
    logic signed [32:0] m_dysx_reg, m_dxsy_reg, m_pxsy_reg, m_pysx_reg;
    logic signed [31:0] m_pxdy_reg, m_dxpy_reg;

    always_ff @(posedge clk)
    begin
        m_dysx_reg <= dir_y_reg * sx_reg;
        m_dxsy_reg <= dir_x_reg * sy_reg;
        m_pxsy_reg <= plane_x_reg * sy_reg;
        m_pysx_reg <= plane_y_reg * sx_reg;
        m_pxdy_reg <= plane_x_reg * dir_y_reg;
        m_dxpy_reg <= dir_x_reg * plane_y_reg;
    end

    // Stage 3: numerators and determinant.
    logic signed [33:0] num_cam_reg, num_dep_reg;
    logic signed [32:0] det_reg;

    always_ff @(posedge clk)
    begin
        num_cam_reg <= 34'(m_dysx_reg) - 34'(m_dxsy_reg);
        num_dep_reg <= 34'(m_pxsy_reg) - 34'(m_pysx_reg);
        det_reg     <= 33'(m_pxdy_reg) - 33'(m_dxpy_reg);
    end

    logic [33:0]   abs_cam, abs_dep;
    logic [32:0]   abs_det;
    spp_cam_side_t cam_side;

    always_comb
    begin
        abs_cam = num_cam_reg[33] ? 34'(-num_cam_reg) : 34'(num_cam_reg);
        abs_dep = num_dep_reg[33] ? 34'(-num_dep_reg) : 34'(num_dep_reg);
        abs_det = det_reg[32] ? 33'(-det_reg) : 33'(det_reg);
        cam_side.neg_cam  = num_cam_reg[33] ^ det_reg[32];
        cam_side.neg_dep  = num_dep_reg[33] ^ det_reg[32];
        cam_side.det_zero = det_reg == '0;
    end

    logic [CamQW-1:0] q_cam, q_dep;
    logic             ovf_cam, ovf_dep, dep_valid;

    spp_div #(.NW(CamNumW), .DW(CamDenW), .QW(CamQW)) u_div_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       ({abs_cam, 14'd0}),
        .den       (abs_det),
        .out_valid (cam_valid),
        .quo       (q_cam),
        .ovf       (ovf_cam)
    );

    spp_div #(.NW(CamNumW), .DW(CamDenW), .QW(CamQW)) u_div_dep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       ({abs_dep, 14'd0}),
        .den       (abs_det),
        .out_valid (dep_valid),
        .quo       (q_dep),
        .ovf       (ovf_dep)
    );

    spp_cam_side_t cam_line_reg [CamLat];

    always_ff @(posedge clk)
    begin
        cam_line_reg[0] <= cam_side;
        for (int i = 1; i < CamLat; i++)
        begin
            cam_line_reg[i] <= cam_line_reg[i-1];
        end
    end

    function automatic logic signed [23:0] sat_cam(input logic [CamQW-1:0] q,
                                                   input logic ovf, input logic neg);
        logic signed [23:0] r;
        if (!neg)
        begin
            r = (ovf || q[23]) ? 24'sh7FFFFF : $signed(q);
        end
        else
        begin
            r = (ovf || q > 24'h800000) ? 24'sh800000 : $signed(24'd0 - q);
        end
        return r;
    endfunction

    // Stage 4: camera-space point.
    logic signed [23:0] camx_reg, dep4_reg;
    spp_cam_side_t      cs_out;

    assign cs_out = cam_line_reg[CamLat-1];

    always_ff @(posedge clk)
    begin
        if (cs_out.det_zero)
        begin
            camx_reg <= '0;
            dep4_reg <= '0;
        end
        else
        begin
            camx_reg <= sat_cam(q_cam, ovf_cam, cs_out.neg_cam);
            dep4_reg <= sat_cam(q_dep, ovf_dep, cs_out.neg_dep);
        end
    end

    // Stage 5: center numerator and depth magnitude.
    logic signed [36:0] prod_reg;
    logic signed [23:0] dep5_reg;
    logic [23:0]        ad_reg;
    logic signed [24:0] dsum;
    logic signed [12:0] half_s;

    always_comb
    begin
        dsum   = 25'(dep4_reg) + 25'(camx_reg);
        half_s = $signed({1'b0, width_reg[12:1]});
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 37'(half_s * dsum);
        dep5_reg <= dep4_reg;
        ad_reg   <= dep4_reg[23] ? 24'(-dep4_reg) : 24'(dep4_reg);
    end

    logic [CtrNumW-1:0] abs_prod;
    spp_proj_side_t     proj_side;

    always_comb
    begin
        abs_prod             = prod_reg[36] ? 37'(-prod_reg) : 37'(prod_reg);
        proj_side.depth      = dep5_reg;
        proj_side.depth_zero = dep5_reg == '0;
        proj_side.prod_neg   = prod_reg[36] ^ dep5_reg[23];
        proj_side.prod_zero  = prod_reg == '0;
    end

    logic [ProjQW-1:0] q_ctr, q_size;
    logic              ovf_ctr, ovf_size, size_valid;

    spp_div #(.NW(CtrNumW), .DW(ProjDenW), .QW(ProjQW)) u_div_ctr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (abs_prod),
        .den       (ad_reg),
        .out_valid (proj_valid),
        .quo       (q_ctr),
        .ovf       (ovf_ctr)
    );

    spp_div #(.NW(SizeNumW), .DW(ProjDenW), .QW(ProjQW)) u_div_size (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       ({height_reg, 8'd0}),
        .den       (ad_reg),
        .out_valid (size_valid),
        .quo       (q_size),
        .ovf       (ovf_size)
    );

    spp_proj_side_t proj_line_reg [ProjLat];

    always_ff @(posedge clk)
    begin
        proj_line_reg[0] <= proj_side;
        for (int i = 1; i < ProjLat; i++)
        begin
            proj_line_reg[i] <= proj_line_reg[i-1];
        end
    end

    // Stage 6: center and size. With zero depth the product is half times camera x,
    // so its sign picks the saturation direction.
    logic signed [15:0] center6_reg;
    logic [15:0]        size6_reg;
    logic signed [23:0] dep6_reg;
    logic               dz6_reg;
    spp_proj_side_t     ps_out;

    assign ps_out = proj_line_reg[ProjLat-1];

    always_ff @(posedge clk)
    begin
        dep6_reg <= ps_out.depth;
        dz6_reg  <= ps_out.depth_zero;
        if (ps_out.depth_zero)
        begin
            size6_reg <= 16'hFFFF;
            if (ps_out.prod_zero)
            begin
                center6_reg <= '0;
            end
            else
            begin
                center6_reg <= ps_out.prod_neg ? 16'sh8000 : 16'sh7FFF;
            end
        end
        else
        begin
            size6_reg <= ovf_size ? 16'hFFFF : q_size;
            if (!ps_out.prod_neg)
            begin
                center6_reg <= (ovf_ctr || q_ctr[15]) ? 16'sh7FFF : $signed(q_ctr);
            end
            else
            begin
                center6_reg <= (ovf_ctr || q_ctr > 16'h8000) ? 16'sh8000
                                                               : $signed(16'd0 - q_ctr);
            end
        end
    end

    // Stage 7: clamped extents.
    logic signed [17:0] hs, hh, c18, rs, re, cs, ce, w18, h18;

    always_comb
    begin
        hs  = $signed({3'd0, size6_reg[15:1]});
        hh  = $signed({6'd0, height_reg[12:1]});
        c18 = 18'(center6_reg);
        w18 = $signed({5'd0, width_reg});
        h18 = $signed({5'd0, height_reg});
        rs  = hh - hs;
        re  = hh + hs;
        cs  = c18 - hs;
        ce  = c18 + hs;
        if (rs < 0)
        begin
            rs = '0;
        end
        if (re >= h18)
        begin
            re = h18 - 18'sd1;
        end
        if (cs < 0)
        begin
            cs = '0;
        end
        if (ce >= w18)
        begin
            ce = w18 - 18'sd1;
        end
    end

    always_ff @(posedge clk)
    begin
        center_column <= center6_reg;
        depth         <= dep6_reg;
        sprite_size   <= size6_reg;
        depth_zero    <= dz6_reg;
        row_start     <= rs[15:0];
        row_end       <= re[15:0];
        column_start  <= cs[15:0];
        column_end    <= ce[15:0];
    end

    assign done = v7_reg;

endmodule
